@@ design/utg_pkg.sv @@
// ----------------------------------------------------------------------------
// utg_pkg
// Types, codes and sizes shared by the generation tracker modules.
// ----------------------------------------------------------------------------
package utg_pkg;

  localparam int unsigned MAX_TRANSFERS = 255;
  localparam int unsigned STAT_WIDTH    = 32;

  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned GEN_W      = 64;
  localparam int unsigned STAT_OUT_W = 32;

  localparam int unsigned IN_TUSER_W   = 4;
  localparam int unsigned IN_FIELDS_W  = COUNT_W + GEN_W + 2 + 2;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 1 + 3 + 1 + 1 + 2 + 1 + 2 * COUNT_W + 4 * STAT_OUT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [GEN_W-1:0]      gen_t;
  typedef logic [STAT_WIDTH-1:0] stat_t;

  typedef enum logic [2:0] {
    CMD_ALLOCATE    = 3'd0,
    CMD_SUBMIT      = 3'd1,
    CMD_FAIL_SUBMIT = 3'd2,
    CMD_BEGIN_STOP  = 3'd3,
    CMD_RETIRE      = 3'd4,
    CMD_CANCEL      = 3'd5,
    CMD_COMPLETION  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    DISP_INVALID  = 3'd0,
    DISP_RESUBMIT = 3'd1,
    DISP_SETTLED  = 3'd2,
    DISP_STALE    = 3'd3,
    DISP_DETACHED = 3'd4
  } disp_t;

  typedef enum logic [1:0] {
    LIFE_ACTIVE      = 2'd0,
    LIFE_STOPPING    = 2'd1,
    LIFE_RETIRED     = 2'd2,
    LIFE_RECLAIMABLE = 2'd3
  } life_t;

  typedef enum logic [1:0] {
    STATUS_COMPLETED = 2'd0,
    STATUS_ERROR     = 2'd1,
    STATUS_NO_DEVICE = 2'd2,
    STATUS_OTHER     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OUTCOME_CANCELLED = 2'd0,
    OUTCOME_NOT_FOUND = 2'd1,
    OUTCOME_FAILED    = 2'd2,
    OUTCOME_UNDEFINED = 2'd3
  } outcome_t;

  localparam logic REG_OWN_GENERATION = 1'b0;

  typedef struct packed {
    logic [1:0]   cancel_outcome;
    logic [1:0]   completion_status;
    gen_t         callback_generation;
    count_t       count;
    logic         transfer_set;
    logic [2:0]   command;
  } item_t;

  // first member lands in the top bits, so accepted is bit 0
  typedef struct packed {
    logic [STAT_OUT_W-1:0] set_cancel_not_found;
    logic [STAT_OUT_W-1:0] set_errors;
    logic [STAT_OUT_W-1:0] set_completions;
    logic [STAT_OUT_W-1:0] set_submissions;
    count_t                set_in_flight;
    count_t                set_allocated;
    logic                  device_online;
    logic [1:0]            lifecycle_state;
    logic                  terminal_stop_latched;
    logic                  terminal_stop_raised;
    logic [2:0]            disposition;
    logic                  accepted;
  } result_t;

endpackage

@@ design/utg_cfg.sv @@
// ----------------------------------------------------------------------------
// utg_cfg
// Configuration register file holding the owned generation number.
// ----------------------------------------------------------------------------
module utg_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [utg_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [utg_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [utg_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output utg_pkg::gen_t                   own_gen
);
  import utg_pkg::*;

  gen_t own_gen_r;
  logic reg_idx;
  logic wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == REG_OWN_GENERATION) ? CFG_DATA_W'(own_gen_r) : '0;
  assign own_gen    = own_gen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_gen_r <= '0;
    end else if (wr_en && reg_idx == REG_OWN_GENERATION) begin
      own_gen_r <= GEN_W'(cfg_pwdata);
    end
  end

endmodule

@@ design/utg_in_stage.sv @@
// ----------------------------------------------------------------------------
// utg_in_stage
// Input register that holds one command until the engine takes it.
// ----------------------------------------------------------------------------
module utg_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  utg_pkg::item_t in_item,
  output logic           in_ready,
  input  logic           take,
  output logic           valid,
  output utg_pkg::item_t item
);
  import utg_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || take;
  assign valid    = valid_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ design/utg_engine.sv @@
// ----------------------------------------------------------------------------
// utg_engine
// Lifecycle state, per-set counters and the combinational command evaluation.
// ----------------------------------------------------------------------------
module utg_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  utg_pkg::item_t   item,
  input  utg_pkg::gen_t    own_gen,
  output utg_pkg::result_t res
);
  import utg_pkg::*;

  life_t  life_r;
  logic   online_r;
  logic   latch_r;
  count_t alloc_r [2];
  count_t infl_r  [2];
  stat_t  subs_r  [2];
  stat_t  comp_r  [2];
  stat_t  err_r   [2];
  stat_t  nf_r    [2];

  life_t  life_nxt;
  logic   online_nxt;
  logic   latch_nxt;
  count_t alloc_nxt;
  count_t infl_nxt;
  stat_t  subs_nxt;
  stat_t  comp_nxt;
  stat_t  err_nxt;
  stat_t  nf_nxt;

  logic   s;
  cmd_t   cmd;
  count_t cnt;
  logic   acc;
  disp_t  disp;
  logic   raised;
  logic   reclaim_chk;
  logic [COUNT_W:0]    free_cnt;
  logic [STAT_WIDTH:0] subs_sum;
  logic [STAT_WIDTH:0] err_sum;

  assign s   = item.transfer_set;
  assign cmd = cmd_t'(item.command);
  assign cnt = item.count;

  always_comb begin
    life_nxt    = life_r;
    online_nxt  = online_r;
    latch_nxt   = latch_r;
    alloc_nxt   = alloc_r[s];
    infl_nxt    = infl_r[s];
    subs_nxt    = subs_r[s];
    comp_nxt    = comp_r[s];
    err_nxt     = err_r[s];
    nf_nxt      = nf_r[s];
    acc         = 1'b0;
    disp        = DISP_INVALID;
    raised      = 1'b0;
    reclaim_chk = 1'b0;
    free_cnt    = {1'b0, alloc_r[s]} - {1'b0, infl_r[s]};
    subs_sum    = {1'b0, subs_r[s]} + (STAT_WIDTH + 1)'(cnt);
    err_sum     = {1'b0, err_r[s]} + (STAT_WIDTH + 1)'(cnt);
    case (cmd)
      CMD_ALLOCATE: begin
        if (cnt != '0 && int'(cnt) <= MAX_TRANSFERS && life_r == LIFE_ACTIVE &&
            alloc_r[s] == '0) begin
          alloc_nxt = cnt;
          acc       = 1'b1;
        end
      end
      CMD_SUBMIT: begin
        if (cnt != '0 && life_r == LIFE_ACTIVE && online_r && !free_cnt[COUNT_W] &&
            {1'b0, cnt} <= free_cnt && !subs_sum[STAT_WIDTH]) begin
          subs_nxt = subs_sum[STAT_WIDTH-1:0];
          infl_nxt = infl_r[s] + cnt;
          acc      = 1'b1;
        end
      end
      CMD_FAIL_SUBMIT: begin
        if (cnt != '0 && cnt <= infl_r[s] && !err_sum[STAT_WIDTH]) begin
          infl_nxt    = infl_r[s] - cnt;
          err_nxt     = err_sum[STAT_WIDTH-1:0];
          reclaim_chk = 1'b1;
          acc         = 1'b1;
        end
      end
      CMD_BEGIN_STOP: begin
        if (life_r == LIFE_ACTIVE) begin
          life_nxt = LIFE_STOPPING;
          acc      = 1'b1;
        end
      end
      CMD_RETIRE: begin
        if (life_r == LIFE_STOPPING) begin
          life_nxt    = LIFE_RETIRED;
          reclaim_chk = 1'b1;
          acc         = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (life_r inside {LIFE_STOPPING, LIFE_RETIRED}) begin
          case (outcome_t'(item.cancel_outcome))
            OUTCOME_NOT_FOUND: begin
              nf_nxt      = nf_r[s] + STAT_WIDTH'(1);
              infl_nxt    = '0;
              reclaim_chk = 1'b1;
            end
            OUTCOME_FAILED: begin
              err_nxt = err_r[s] + STAT_WIDTH'(1);
            end
            default: begin
            end
          endcase
          acc = 1'b1;
        end
      end
      CMD_COMPLETION: begin
        if (infl_r[s] == '0) begin
          disp = DISP_INVALID;
        end else if (item.callback_generation != own_gen) begin
          disp = DISP_STALE;
        end else begin
          acc         = 1'b1;
          reclaim_chk = 1'b1;
          infl_nxt    = infl_r[s] - COUNT_W'(1);
          comp_nxt    = comp_r[s] + STAT_WIDTH'(1);
          if (item.completion_status inside {STATUS_ERROR, STATUS_NO_DEVICE}) begin
            err_nxt = err_r[s] + STAT_WIDTH'(1);
          end
          if (status_t'(item.completion_status) == STATUS_NO_DEVICE) begin
            online_nxt = 1'b0;
            latch_nxt  = 1'b1;
            raised     = !latch_r;
            if (life_r == LIFE_ACTIVE) begin
              life_nxt = LIFE_STOPPING;
            end
            disp = DISP_DETACHED;
          end else if (life_r == LIFE_ACTIVE && online_r &&
                       status_t'(item.completion_status) == STATUS_COMPLETED) begin
            disp = DISP_RESUBMIT;
          end else begin
            disp = DISP_SETTLED;
          end
        end
      end
      default: begin
      end
    endcase
    if (reclaim_chk && life_nxt == LIFE_RETIRED && infl_nxt == '0 && infl_r[!s] == '0) begin
      life_nxt = LIFE_RECLAIMABLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r   <= LIFE_ACTIVE;
      online_r <= 1'b1;
      latch_r  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        alloc_r[i] <= '0;
        infl_r[i]  <= '0;
        subs_r[i]  <= '0;
        comp_r[i]  <= '0;
        err_r[i]   <= '0;
        nf_r[i]    <= '0;
      end
    end else if (step_en) begin
      life_r     <= life_nxt;
      online_r   <= online_nxt;
      latch_r    <= latch_nxt;
      alloc_r[s] <= alloc_nxt;
      infl_r[s]  <= infl_nxt;
      subs_r[s]  <= subs_nxt;
      comp_r[s]  <= comp_nxt;
      err_r[s]   <= err_nxt;
      nf_r[s]    <= nf_nxt;
    end
  end

  always_comb begin
    res.accepted              = acc;
    res.disposition           = disp;
    res.terminal_stop_raised  = raised;
    res.terminal_stop_latched = latch_nxt;
    res.lifecycle_state       = life_nxt;
    res.device_online         = online_nxt;
    res.set_allocated         = alloc_nxt;
    res.set_in_flight         = infl_nxt;
    res.set_submissions       = STAT_OUT_W'(subs_nxt);
    res.set_completions       = STAT_OUT_W'(comp_nxt);
    res.set_errors            = STAT_OUT_W'(err_nxt);
    res.set_cancel_not_found  = STAT_OUT_W'(nf_nxt);
  end

endmodule

@@ design/usb_transfer_generation_tracker.sv @@
// ----------------------------------------------------------------------------
// usb_transfer_generation_tracker
// Lifecycle and counter tracker for one stream generation of two transfer sets.
// ----------------------------------------------------------------------------
// Commands enter on the in_ stream, one per transfer, and each gives exactly
// one result on the out_ stream in the same order. The result carries the
// accept flag, the completion disposition, the lifecycle and online flags and
// the counters of the named set, all as they stand after the command.
// The owned generation is written over the cfg_ port; the user must do so only
// while no command is in progress, which the block does not enforce. Completions
// carrying another tag are reported stale. A command sits in the input register
// and is evaluated into the result register. Throughput is one command per cycle
// while the receiver does not stall, set by the single evaluation stage that
// reads and updates the state registers.
// While the result register is held by a stalled receiver, one more command
// waits in the input register; in_tready drops only when both are full.
// Reset clears both stages and returns the tracker to active and online with
// all counters zero and the owned generation zero.
// ----------------------------------------------------------------------------
module usb_transfer_generation_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // count, callback_generation, completion_status, cancel_outcome, zero pad
  input  logic [utg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command, transfer_set
  input  logic [utg_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // accepted, disposition, terminal_stop_raised, terminal_stop_latched,
  // lifecycle_state, device_online, set_allocated, set_in_flight,
  // set_submissions, set_completions, set_errors, set_cancel_not_found, zero pad
  output logic [utg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [utg_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [utg_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [utg_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import utg_pkg::*;

  gen_t    own_gen;
  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    take;
  result_t res;
  result_t res_r;
  logic    out_valid_r;

  assign in_item.command             = in_tuser[2:0];
  assign in_item.transfer_set        = in_tuser[3];
  assign in_item.count               = in_tdata[COUNT_W-1:0];
  assign in_item.callback_generation = in_tdata[COUNT_W+GEN_W-1:COUNT_W];
  assign in_item.completion_status   = in_tdata[COUNT_W+GEN_W+1:COUNT_W+GEN_W];
  assign in_item.cancel_outcome      = in_tdata[COUNT_W+GEN_W+3:COUNT_W+GEN_W+2];

  utg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .own_gen     (own_gen)
  );

  utg_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_item  (in_item),
    .in_ready (in_tready),
    .take     (take),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  assign take = s1_valid && (!out_valid_r || out_tready);

  utg_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .item    (s1_item),
    .own_gen (own_gen),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), res_r};

endmodule

@@ design/utg_checker.sv @@
// ----------------------------------------------------------------------------
// utg_checker
// Port-level checks for the generation tracker, bound to the top level.
// ----------------------------------------------------------------------------
module utg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [utg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import utg_pkg::*;

  // result register stays put while the receiver stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty result register never backs up the input side
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:1] == DISP_STALE || out_tdata[3:1] == DISP_INVALID) &&
    out_tdata[4] |-> 1'b0)
    else $error("stop raised without a detach");

  // a raised stop comes with a detach, the latch set and the device offline
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |->
      out_tdata[0] && out_tdata[5] && !out_tdata[8] && out_tdata[3:1] == DISP_DETACHED)
    else $error("inconsistent terminal stop");

endmodule

bind usb_transfer_generation_tracker utg_checker u_utg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/tb_usb_transfer_generation_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_usb_transfer_generation_tracker
// Self-checking bench for the transfer generation tracker. A mirror of the
// tracker state predicts the result of every accepted command. Each result
// transfer is compared field by field against the oldest prediction.
// The run opens with directed commands, then random traffic that walks the
// tracker from active through stopping and retired to reclaimable.
// Receiver stalls are random throughout, sender bursts during the random traffic.
// ----------------------------------------------------------------------------
module tb_usb_transfer_generation_tracker;
  import utg_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 6;

  localparam logic [2:0] CMD_UNDEFINED = 3'd7;
  localparam logic       SET_AUDIO     = 1'b0;
  localparam logic       SET_FEEDBACK  = 1'b1;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_PATTERN,
    RX_SLUGGISH
  } rx_mode_t;

  typedef struct packed {
    logic [2:0] command;
    logic       xfer_set;
    count_t     count;
    gen_t       tag;
    logic [1:0] status;
    logic [1:0] outcome;
  } tracker_cmd_t;

  class transfer_tracker_mirror;
    gen_t    own_gen;
    life_t   life;
    bit      online;
    bit      stop_latched;
    count_t  alloc[2];
    count_t  in_flight[2];
    stat_t   submitted[2];
    stat_t   completed[2];
    stat_t   errored[2];
    stat_t   not_found[2];
    result_t pending_results[$];
    int unsigned failures;
    int unsigned result_count;

    function new();
      own_gen      = '0;
      life         = LIFE_ACTIVE;
      online       = 1'b1;
      stop_latched = 1'b0;
      failures     = 0;
      result_count = 0;
      for (int i = 0; i < 2; i++) begin
        alloc[i]     = '0;
        in_flight[i] = '0;
        submitted[i] = '0;
        completed[i] = '0;
        errored[i]   = '0;
        not_found[i] = '0;
      end
    endfunction

    function void reclaim_if_drained();
      if (life == LIFE_RETIRED && in_flight[0] == 0 && in_flight[1] == 0)
        life = LIFE_RECLAIMABLE;
    endfunction

    function void apply_command(tracker_cmd_t c);
      result_t     r;
      int unsigned s;
      stat_t       stat_max;
      r        = '0;
      s        = c.xfer_set;
      stat_max = '1;
      case (c.command)
        CMD_ALLOCATE: begin
          if (c.count != 0 && c.count <= MAX_TRANSFERS && life == LIFE_ACTIVE &&
              alloc[s] == 0) begin
            alloc[s]   = c.count;
            r.accepted = 1'b1;
          end
        end
        CMD_SUBMIT: begin
          if (c.count != 0 && life == LIFE_ACTIVE && online &&
              in_flight[s] <= alloc[s] && c.count <= alloc[s] - in_flight[s] &&
              stat_t'(c.count) <= stat_max - submitted[s]) begin
            submitted[s] = submitted[s] + stat_t'(c.count);
            in_flight[s] = in_flight[s] + c.count;
            r.accepted   = 1'b1;
          end
        end
        CMD_FAIL_SUBMIT: begin
          if (c.count != 0 && c.count <= in_flight[s] &&
              stat_t'(c.count) <= stat_max - errored[s]) begin
            in_flight[s] = in_flight[s] - c.count;
            errored[s]   = errored[s] + stat_t'(c.count);
            reclaim_if_drained();
            r.accepted   = 1'b1;
          end
        end
        CMD_BEGIN_STOP: begin
          if (life == LIFE_ACTIVE) begin
            life       = LIFE_STOPPING;
            r.accepted = 1'b1;
          end
        end
        CMD_RETIRE: begin
          if (life == LIFE_STOPPING) begin
            life = LIFE_RETIRED;
            reclaim_if_drained();
            r.accepted = 1'b1;
          end
        end
        CMD_CANCEL: begin
          if (life == LIFE_STOPPING || life == LIFE_RETIRED) begin
            if (c.outcome == OUTCOME_NOT_FOUND) begin
              not_found[s] = not_found[s] + 1'b1;
              in_flight[s] = '0;
              reclaim_if_drained();
            end else if (c.outcome == OUTCOME_FAILED) begin
              errored[s] = errored[s] + 1'b1;
            end
            r.accepted = 1'b1;
          end
        end
        CMD_COMPLETION: begin
          if (in_flight[s] == 0) begin
            r.disposition = DISP_INVALID;
          end else if (c.tag != own_gen) begin
            r.disposition = DISP_STALE;
          end else begin
            r.accepted   = 1'b1;
            in_flight[s] = in_flight[s] - 1'b1;
            completed[s] = completed[s] + 1'b1;
            if (c.status == STATUS_ERROR || c.status == STATUS_NO_DEVICE)
              errored[s] = errored[s] + 1'b1;
            if (c.status == STATUS_NO_DEVICE) begin
              online = 1'b0;
              if (!stop_latched) begin
                stop_latched           = 1'b1;
                r.terminal_stop_raised = 1'b1;
              end
              if (life == LIFE_ACTIVE)
                life = LIFE_STOPPING;
              r.disposition = DISP_DETACHED;
            end else if (life == LIFE_ACTIVE && online &&
                         c.status == STATUS_COMPLETED) begin
              r.disposition = DISP_RESUBMIT;
            end else begin
              r.disposition = DISP_SETTLED;
            end
            reclaim_if_drained();
          end
        end
        default: begin
        end
      endcase
      r.terminal_stop_latched = stop_latched;
      r.lifecycle_state       = life;
      r.device_online         = online;
      r.set_allocated         = alloc[s];
      r.set_in_flight         = in_flight[s];
      r.set_submissions       = submitted[s];
      r.set_completions       = completed[s];
      r.set_errors            = errored[s];
      r.set_cancel_not_found  = not_found[s];
      pending_results = {pending_results, r};
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", result_count, msg);
      failures++;
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no command outstanding");
        return;
      end
      want = pending_results.pop_front();
      check_field("accepted", got.accepted, want.accepted);
      check_field("disposition", got.disposition, want.disposition);
      check_field("terminal_stop_raised", got.terminal_stop_raised,
                  want.terminal_stop_raised);
      check_field("terminal_stop_latched", got.terminal_stop_latched,
                  want.terminal_stop_latched);
      check_field("lifecycle_state", got.lifecycle_state, want.lifecycle_state);
      check_field("device_online", got.device_online, want.device_online);
      check_field("set_allocated", got.set_allocated, want.set_allocated);
      check_field("set_in_flight", got.set_in_flight, want.set_in_flight);
      check_field("set_submissions", got.set_submissions, want.set_submissions);
      check_field("set_completions", got.set_completions, want.set_completions);
      check_field("set_errors", got.set_errors, want.set_errors);
      check_field("set_cancel_not_found", got.set_cancel_not_found,
                  want.set_cancel_not_found);
      result_count++;
    endtask
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  transfer_tracker_mirror mirror;

  logic [31:0] ready_phase   = '0;
  logic [15:0] stall_pattern = '1;
  rx_mode_t    stall_mode    = RX_STREAM;
  int unsigned idle_cycles   = 0;

  usb_transfer_generation_tracker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // receiver stall pattern, re-chosen whenever the low bits of ready_phase return to zero
  always @(posedge clk) begin
    ready_phase = ready_phase + 1'b1;
    if (ready_phase[5:0] == 0) begin
      stall_mode    = rx_mode_t'($urandom_range(0, 3));
      stall_pattern = 16'($urandom);
    end
    case (stall_mode)
      RX_STREAM:  out_tready <= 1'b1;
      RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
      RX_PATTERN: out_tready <= stall_pattern[ready_phase[3:0]];
      default:    out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      mirror.check_result(result_t'(out_tdata[OUT_FIELDS_W-1:0]));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic tracker_cmd_t shape(logic [2:0] op, logic xfer_set, count_t n,
                                         gen_t tag, logic [1:0] st, logic [1:0] oc);
    tracker_cmd_t c;
    c.command  = op;
    c.xfer_set = xfer_set;
    c.count    = n;
    c.tag      = tag;
    c.status   = st;
    c.outcome  = oc;
    return c;
  endfunction

  // mostly well-formed commands for the current lifecycle, the rest noise
  function automatic tracker_cmd_t make_command();
    tracker_cmd_t c;
    int unsigned  roll;
    int unsigned  s;
    bit           running;
    c.command  = 3'($urandom_range(0, 7));
    c.xfer_set = 1'($urandom_range(0, 1));
    c.count    = 8'($urandom_range(0, 255));
    c.tag      = {$urandom, $urandom};
    c.status   = 2'($urandom_range(0, 3));
    c.outcome  = 2'($urandom_range(0, 3));
    s          = c.xfer_set;
    running    = (mirror.life == LIFE_ACTIVE);
    if ($urandom_range(0, 99) < 85) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) != 0)
        c.tag = mirror.own_gen;
      if (running) begin
        if (mirror.alloc[s] == 0) begin
          c.command = CMD_ALLOCATE;
          c.count   = 8'($urandom_range(1, MAX_TRANSFERS));
        end else if (roll < 35 && mirror.alloc[s] > mirror.in_flight[s]) begin
          c.command = CMD_SUBMIT;
          c.count   = 8'($urandom_range(1, mirror.alloc[s] - mirror.in_flight[s]));
        end else if (roll < 88) begin
          c.command = CMD_COMPLETION;
        end else begin
          c.command = CMD_FAIL_SUBMIT;
          c.count   = 8'($urandom_range(1, (mirror.in_flight[s] > 0) ?
                                           mirror.in_flight[s] : 1));
        end
      end else begin
        if (roll < 55) begin
          c.command = CMD_COMPLETION;
        end else if (roll < 88) begin
          c.command = CMD_CANCEL;
          if (c.outcome == OUTCOME_NOT_FOUND && $urandom_range(0, 2) != 0)
            c.outcome = OUTCOME_CANCELLED;
        end else begin
          c.command = CMD_FAIL_SUBMIT;
          c.count   = 8'($urandom_range(1, (mirror.in_flight[s] > 0) ?
                                           mirror.in_flight[s] : 1));
        end
      end
    end
    // lifecycle moves only where the sequence decides it
    if (running && c.status == STATUS_NO_DEVICE)
      c.status = STATUS_COMPLETED;
    if (running && c.command == CMD_BEGIN_STOP)
      c.command = CMD_CANCEL;
    if (mirror.life == LIFE_STOPPING && c.command == CMD_RETIRE)
      c.command = CMD_CANCEL;
    return c;
  endfunction

  task automatic send_command(tracker_cmd_t c);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({c.outcome, c.status, c.tag, c.count});
    in_tuser  <= {c.xfer_set, c.command};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.apply_command(c);
  endtask

  task automatic run_commands(int unsigned n);
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(1, 12);
    repeat (n) begin
      send_command(make_command());
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
                                              $urandom_range(1, 12);
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_generation(gen_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(8 * REG_OWN_GENERATION);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    mirror.own_gen = value;
  endtask

  initial begin
    mirror = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_own_generation('0);

    // directed opening while active
    send_command(shape(CMD_ALLOCATE, SET_AUDIO, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_SUBMIT, SET_AUDIO, 8'd1, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_ALLOCATE, SET_AUDIO, 8'd255, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_ALLOCATE, SET_AUDIO, 8'd5, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_ALLOCATE, SET_FEEDBACK, 8'd1, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_SUBMIT, SET_AUDIO, 8'd255, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_SUBMIT, SET_AUDIO, 8'd1, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_SUBMIT, SET_FEEDBACK, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_SUBMIT, SET_FEEDBACK, 8'd1, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, '1, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, '0, STATUS_ERROR,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, '0, STATUS_OTHER,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_FAIL_SUBMIT, SET_AUDIO, 8'd255, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_FAIL_SUBMIT, SET_AUDIO, 8'd2, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_CANCEL, SET_AUDIO, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_NOT_FOUND));
    send_command(shape(CMD_RETIRE, SET_AUDIO, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_UNDEFINED, SET_FEEDBACK, 8'd255, '1, STATUS_OTHER,
                       OUTCOME_UNDEFINED));
    send_command(shape(CMD_CANCEL, SET_FEEDBACK, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_UNDEFINED));
    send_command(shape(CMD_COMPLETION, SET_FEEDBACK, 8'd0, '0, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));

    run_commands(80);
    wait_drained();
    write_own_generation('1);
    run_commands(120);
    wait_drained();
    write_own_generation({$urandom, $urandom});
    run_commands(40);

    // wind down either by an explicit stop or by the device going away
    send_command(shape(CMD_SUBMIT, SET_AUDIO, 8'd1, mirror.own_gen, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    if ($urandom_range(0, 1) == 0) begin
      send_command(shape(CMD_BEGIN_STOP, SET_AUDIO, 8'd0, mirror.own_gen,
                         STATUS_COMPLETED, OUTCOME_CANCELLED));
      send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, mirror.own_gen,
                         STATUS_NO_DEVICE, OUTCOME_CANCELLED));
    end else begin
      send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, mirror.own_gen,
                         STATUS_NO_DEVICE, OUTCOME_CANCELLED));
      send_command(shape(CMD_BEGIN_STOP, SET_AUDIO, 8'd0, mirror.own_gen,
                         STATUS_COMPLETED, OUTCOME_CANCELLED));
    end
    send_command(shape(CMD_COMPLETION, SET_AUDIO, 8'd0, mirror.own_gen,
                       STATUS_NO_DEVICE, OUTCOME_CANCELLED));
    run_commands(40);
    wait_drained();
    write_own_generation({$urandom, $urandom});
    run_commands(40);

    send_command(shape(CMD_RETIRE, SET_AUDIO, 8'd0, mirror.own_gen, STATUS_COMPLETED,
                       OUTCOME_CANCELLED));
    send_command(shape(CMD_RETIRE, SET_FEEDBACK, 8'd0, mirror.own_gen,
                       STATUS_COMPLETED, OUTCOME_CANCELLED));
    run_commands(50);

    // drain both sets so the tracker becomes reclaimable
    send_command(shape(CMD_CANCEL, SET_AUDIO, 8'd0, mirror.own_gen, STATUS_COMPLETED,
                       OUTCOME_NOT_FOUND));
    send_command(shape(CMD_CANCEL, SET_FEEDBACK, 8'd0, mirror.own_gen,
                       STATUS_COMPLETED, OUTCOME_NOT_FOUND));
    send_command(shape(CMD_CANCEL, SET_AUDIO, 8'd0, mirror.own_gen, STATUS_COMPLETED,
                       OUTCOME_FAILED));
    send_command(shape(CMD_COMPLETION, SET_FEEDBACK, 8'd0, mirror.own_gen,
                       STATUS_COMPLETED, OUTCOME_CANCELLED));
    send_command(shape(CMD_BEGIN_STOP, SET_AUDIO, 8'd0, mirror.own_gen,
                       STATUS_COMPLETED, OUTCOME_CANCELLED));
    run_commands(15);

    wait_drained();
    if (mirror.failures == 0 && mirror.pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
